FILE: design/hfpl_pkg.sv
package hfpl_pkg;

    // Item fields as they arrive on the stream.
    localparam int ALLELE_W   = 4;
    localparam int PROB_W     = 16;
    localparam int NUM_STATES = 4;

    // Result fields.
    localparam int MANT_W  = 32;
    localparam int SHIFT_W = 26;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = '1;

    // Stream payload layout, lowest field first.
    localparam int ALLELE_LSB = 0;
    localparam int EMIT_LSB   = ALLELE_LSB + ALLELE_W;
    localparam int TRANS_LSB  = EMIT_LSB + NUM_STATES * PROB_W;
    localparam int S_FIELDS_W = TRANS_LSB + 3 * PROB_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = MANT_W + SHIFT_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // Site queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [PROB_W-1:0] prob_t;

    // One classified site: emit[j] is the emission already picked for state j.
    typedef struct packed {
        prob_t [NUM_STATES-1:0] emit;
        prob_t                  t_both;
        prob_t                  t_one;
        prob_t                  t_none;
        logic                   first_site;
        logic                   last_site;
    } site_job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MIX,
        BK_SEARCH,
        BK_APPLY,
        BK_FINAL
    } back_state_t;

endpackage

FILE: design/hfpl_front.sv
module hfpl_front
    import hfpl_pkg::*;
(
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  logic                s_tlast,
    output logic                push_valid,
    input  logic                push_ready,
    output site_job_t           push_data
);

    logic [ALLELE_W-1:0]    allele_bits;
    prob_t [NUM_STATES-1:0] emit_by_pair;

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    // State j pairs father template j[1] with mother template j[0]; its
    // emission is the one named by the two template alleles.
    always_comb begin
        logic [1:0] sel;
        sel         = '0;
        allele_bits = s_tdata[ALLELE_LSB +: ALLELE_W];
        for (int p = 0; p < NUM_STATES; p++) begin
            emit_by_pair[p] = s_tdata[EMIT_LSB + p * PROB_W +: PROB_W];
        end
        for (int j = 0; j < NUM_STATES; j++) begin
            sel               = {allele_bits[3 - (j >> 1)], allele_bits[1 - (j & 1)]};
            push_data.emit[j] = emit_by_pair[sel];
        end
        push_data.t_none     = s_tdata[TRANS_LSB +: PROB_W];
        push_data.t_one      = s_tdata[TRANS_LSB + PROB_W +: PROB_W];
        push_data.t_both     = s_tdata[TRANS_LSB + 2 * PROB_W +: PROB_W];
        push_data.first_site = s_tuser;
        push_data.last_site  = s_tlast;
    end

endmodule

FILE: design/hfpl_queue.sv
module hfpl_queue
    import hfpl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  site_job_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output site_job_t pop_data
);

    site_job_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push, pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/hfpl_back.sv
module hfpl_back
    import hfpl_pkg::*;
#(
    parameter int STATE_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    output logic                job_ready,
    input  site_job_t           job,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int SB       = STATE_BITS;
    localparam int PAIR_W   = SB + 1;
    localparam int SUM_W    = SB + 2;
    localparam int PAD_W    = 1 << $clog2(SUM_W);
    localparam int LZ_W     = $clog2(PAD_W) + 1;
    localparam int CNT_W    = $clog2(NUM_STATES + 1);
    localparam int MANT_RSH = (SB >= MANT_W) ? SB - MANT_W : 0;
    localparam int MANT_LSH = (SB < MANT_W) ? MANT_W - SB : 0;
    localparam int CONV_W   = SB + MANT_W;
    localparam logic [CNT_W-1:0] MIX_LAST = CNT_W'(NUM_STATES);
    localparam logic [SB-1:0]    QUARTER  = SB'(1) << (SB - 2);

    back_state_t             state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    site_job_t               job_reg;
    logic [SB-1:0]           l_reg    [NUM_STATES];
    logic [SB-1:0]           prod_reg [NUM_STATES];
    logic [SB-1:0]           b_reg;
    logic [SUM_W-1:0]        acc_reg;
    logic [LZ_W-1:0]         lz_reg;
    logic                    zero_reg;
    logic [SHIFT_W-1:0]      total_reg;
    logic                    out_valid_reg;
    logic [MANT_W-1:0]       out_mant_reg;
    logic [SHIFT_W-1:0]      out_shift_reg;

    logic                    start, out_load, out_free;
    logic [1:0]              mix_idx, emit_idx;
    logic [SB-1:0]           self_op, both_op;
    logic [PAIR_W-1:0]       pair_op;
    logic [SB+PROB_W-1:0]    self_prod, both_prod, emit_prod;
    logic [PAIR_W+PROB_W-1:0] pair_prod;
    logic [SUM_W-1:0]        b_sum;
    logic [SB-1:0]           b_next, e_term;
    logic                    go_right;
    logic [LZ_W-1:0]         r_amt, l_amt;
    logic [SB-1:0]           l_applied [NUM_STATES];
    logic [SHIFT_W-1:0]      total_applied;
    logic [SHIFT_W:0]        total_sum;
    logic [SUM_W-1:0]        final_sum;
    logic [CONV_W-1:0]       mant_wide;

    // Leading zeros of the state sum, found by halving the search window.
    function automatic logic [LZ_W-1:0] count_lead_zeros(input logic [SUM_W-1:0] value);
        logic [PAD_W-1:0] v;
        logic [LZ_W-1:0]  n;
        v = PAD_W'(value) << (PAD_W - SUM_W);
        n = '0;
        for (int step = LZ_W - 2; step >= 0; step--) begin
            if ((v >> (PAD_W - (1 << step))) == '0) begin
                v = v << (1 << step);
                n = n + LZ_W'(1 << step);
            end
        end
        return n;
    endfunction

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        job_ready  = 1'b0;
        start      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (job_valid) begin
                    job_ready  = 1'b1;
                    start      = 1'b1;
                    cnt_next   = '0;
                    state_next = BK_MIX;
                end
            end
            BK_MIX: begin
                if (cnt_reg == MIX_LAST) begin
                    state_next = BK_SEARCH;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            BK_SEARCH: begin
                state_next = BK_APPLY;
            end
            BK_APPLY: begin
                if (job_reg.last_site) begin
                    state_next = BK_FINAL;
                end else if (job_valid) begin
                    job_ready  = 1'b1;
                    start      = 1'b1;
                    cnt_next   = '0;
                    state_next = BK_MIX;
                end else begin
                    state_next = BK_IDLE;
                end
            end
            BK_FINAL: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Mixing: state j takes the no-switch weight on itself, the both-switch
    // weight on its opposite and the one-switch weight on the other two.
    assign mix_idx  = cnt_reg[1:0];
    assign emit_idx = 2'(cnt_reg - 1'b1);

    always_comb begin
        self_op = l_reg[0];
        both_op = l_reg[3];
        pair_op = PAIR_W'(l_reg[1]) + PAIR_W'(l_reg[2]);
        unique case (mix_idx)
            2'd0: begin
                self_op = l_reg[0];
                both_op = l_reg[3];
                pair_op = PAIR_W'(l_reg[1]) + PAIR_W'(l_reg[2]);
            end
            2'd1: begin
                self_op = l_reg[1];
                both_op = l_reg[2];
                pair_op = PAIR_W'(l_reg[0]) + PAIR_W'(l_reg[3]);
            end
            2'd2: begin
                self_op = l_reg[2];
                both_op = l_reg[1];
                pair_op = PAIR_W'(l_reg[0]) + PAIR_W'(l_reg[3]);
            end
            default: begin
                self_op = l_reg[3];
                both_op = l_reg[0];
                pair_op = PAIR_W'(l_reg[1]) + PAIR_W'(l_reg[2]);
            end
        endcase
    end

    assign self_prod = (SB+PROB_W)'(self_op) * (SB+PROB_W)'(job_reg.t_none);
    assign both_prod = (SB+PROB_W)'(both_op) * (SB+PROB_W)'(job_reg.t_both);
    assign pair_prod = (PAIR_W+PROB_W)'(pair_op) * (PAIR_W+PROB_W)'(job_reg.t_one);

    // Each term is at most its operand, so the mixed value stays below the
    // old state sum and fits the state width.
    assign b_sum  = SUM_W'(self_prod[SB+PROB_W-1:PROB_W])
                  + SUM_W'(pair_prod[PAIR_W+PROB_W-1:PROB_W])
                  + SUM_W'(both_prod[SB+PROB_W-1:PROB_W]);
    assign b_next = job_reg.first_site ? QUARTER : b_sum[SB-1:0];

    assign emit_prod = (SB+PROB_W)'(b_reg) * (SB+PROB_W)'(job_reg.emit[emit_idx]);
    assign e_term    = emit_prod[SB+PROB_W-1:PROB_W];

    // Renormalization: a sum at or above one moves right by one or two
    // places, a smaller nonzero sum moves left until its top bit is set.
    assign go_right = (lz_reg < LZ_W'(2));
    assign r_amt    = LZ_W'(2) - lz_reg;
    assign l_amt    = lz_reg - LZ_W'(2);

    always_comb begin
        for (int j = 0; j < NUM_STATES; j++) begin
            if (zero_reg) begin
                l_applied[j] = prod_reg[j];
            end else if (go_right) begin
                l_applied[j] = prod_reg[j] >> r_amt;
            end else begin
                l_applied[j] = prod_reg[j] << l_amt;
            end
        end
        total_sum = {1'b0, total_reg} + (SHIFT_W+1)'(l_amt);
        if (zero_reg) begin
            total_applied = total_reg;
        end else if (go_right) begin
            total_applied = (total_reg > SHIFT_W'(r_amt)) ? total_reg - SHIFT_W'(r_amt) : '0;
        end else if (total_sum > {1'b0, SHIFT_MAX}) begin
            total_applied = SHIFT_MAX;
        end else begin
            total_applied = total_sum[SHIFT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            job_reg <= job;
        end
        if (state_reg == BK_MIX) begin
            if (cnt_reg != MIX_LAST) begin
                b_reg <= b_next;
            end
            if (cnt_reg != '0) begin
                prod_reg[emit_idx] <= e_term;
                acc_reg <= ((cnt_reg == CNT_W'(1)) ? '0 : acc_reg) + SUM_W'(e_term);
            end
        end
        if (state_reg == BK_SEARCH) begin
            lz_reg   <= count_lead_zeros(acc_reg);
            zero_reg <= (acc_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NUM_STATES; j++) begin
                l_reg[j] <= '0;
            end
            total_reg <= '0;
        end else begin
            if (state_reg == BK_APPLY) begin
                for (int j = 0; j < NUM_STATES; j++) begin
                    l_reg[j] <= l_applied[j];
                end
            end
            if (start && job.first_site) begin
                total_reg <= '0;
            end else if (state_reg == BK_APPLY) begin
                total_reg <= total_applied;
            end
        end
    end

    // Result: the normalized states summed and brought to Q0.32.
    always_comb begin
        final_sum = '0;
        for (int j = 0; j < NUM_STATES; j++) begin
            final_sum = final_sum + SUM_W'(l_reg[j]);
        end
        mant_wide = (CONV_W'(final_sum[SB-1:0]) << MANT_LSH) >> MANT_RSH;
    end

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_mant_reg  <= mant_wide[MANT_W-1:0];
            out_shift_reg <= total_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({out_shift_reg, out_mant_reg});

endmodule

FILE: design/hmm_forward_pair_likelihood.sv
// Scaled forward recursion of a four-state pair hidden Markov model. Each beat on the
// slave side carries one site; a beat with tuser set starts a sample, and after a beat
// with tlast set one result beat gives the Q0.32 sum of the normalized states and the
// count of normalizing shifts, so ln L = ln(mantissa / 2^32) - scale_shift * ln 2. The
// recursion state persists across results, so sites that follow a tlast beat without a
// tuser mark continue the same sample. A site that is already queued when the previous
// one finishes goes straight into the four-state mix, which uses a shared emission
// multiplier, then into the leading-zero search and then into the step that applies
// the shift; a site that finds the back end idle is first taken from the idle state. A
// tlast site then forms the result, waiting while the master side still holds the
// previous result, and the back end returns to idle before it takes the next site. The
// front end classifies sites and a two-entry queue holds them, so the slave side can
// run up to two sites ahead of the back end, also while a result waits on the master
// side.

module hmm_forward_pair_likelihood
    import hfpl_pkg::*;
#(
    // Fraction bits of each stored state value (16 to 48).
    parameter int STATE_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    // allele_bits[3:0], emit_for_00[19:4], emit_for_01[35:20], emit_for_10[51:36],
    // emit_for_11[67:52], trans_none[83:68], trans_one[99:84], trans_both[115:100],
    // zero fill [119:116].
    input  logic [S_DATA_W-1:0] s_tdata,
    // first_site[0].
    input  logic                s_tuser,
    // last_site.
    input  logic                s_tlast,

    output logic                m_tvalid,
    input  logic                m_tready,
    // likelihood_mantissa[31:0], scale_shift[57:32], zero fill [63:58].
    output logic [M_DATA_W-1:0] m_tdata
);

    logic      push_valid, push_ready;
    site_job_t push_data;
    logic      pop_valid, pop_ready;
    site_job_t pop_data;

    // The front end picks each state's emission from the allele pair, so the
    // back end only sees per-state weights.
    hfpl_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Two-entry site queue decoupling the stream from the recursion.
    hfpl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // The back end holds the four state values and the shift count, runs the
    // recursion one site at a time and owns the result register.
    hfpl_back #(
        .STATE_BITS (STATE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: design/hfpl_checker.sv
module hfpl_checker
    import hfpl_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tlast,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // Results still owed: tlast beats taken minus result beats delivered.
    logic [2:0] pending_reg, pending_next;
    logic       last_in, result_out;

    assign last_in    = s_tvalid && s_tready && s_tlast;
    assign result_out = m_tvalid && m_tready;

    always_comb begin
        pending_next = pending_reg;
        if (last_in && !result_out) begin
            pending_next = pending_reg + 1'b1;
        end else if (result_out && !last_in) begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    a_reset_clears_result: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_reset_opens_input: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_result_has_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 3'd0)
        else $error("result without a pending last site");

    a_pending_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 3'(QUEUE_DEPTH + 2))
        else $error("more last sites in flight than the block can hold");

endmodule

bind hmm_forward_pair_likelihood hfpl_checker u_checker (.*);
